### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent in any cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Types and codes of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_PREFIX = 6'b000010,
    PH_TYPE   = 6'b000100,
    PH_TIME   = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [15:0] TYPE_REUSE_BIT = 16'h0010;
  localparam logic [31:0] MARK_2B = 32'h0000_4000;
  localparam logic [31:0] MARK_3B = 32'h0020_0000;
  localparam logic [31:0] MARK_4B = 32'h1000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [15:0] packet_type;
    logic [31:0] timestamp;
    logic [31:0] body_length;
    logic        last;
  } result_t;

endpackage

### hw/rtl/length_prefixed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Splits a byte stream into packet headers and body bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_ready is high. Each packet starts
// with a 1- to 5-byte size prefix, then a little-endian 16-bit type and,
// unless type bit 4 is set, a little-endian 32-bit timestamp. The block emits
// one header result, then one result per body byte with last on the final
// one; a zero size emits an end-of-stream result and all later bytes are
// dropped until reset. Every byte is decoded in the cycle it is accepted, and
// its result is registered into the output register, or into a one-entry
// skid register while the output is held; in_ready drops only while the skid
// register is occupied.
`include "assert_macros.svh"

module length_prefixed_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  body_byte,
  output logic [15:0] packet_type,
  output logic [31:0] timestamp,
  output logic [31:0] body_length,
  output logic        last
);
  import lppd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  prefix_lead, prefix_lead_next;
  logic [2:0]  prefix_left, prefix_left_next;
  logic [31:0] size_accum, size_accum_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [2:0]  header_pos, header_pos_next;
  logic [15:0] type_reg, type_reg_next;
  logic [31:0] time_reg, time_reg_next;

  result_t     res;
  logic        res_valid;
  result_t     out_res, skid_res;
  logic        skid_valid;

  logic        accept, res_fire, out_free;
  logic [1:0]  lane_k, lane_t;
  logic [31:0] acc_prefix, acc_time, start_size;
  logic [31:0] bytes_dec;
  logic [15:0] type_full;
  logic        start;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign res_fire = accept && res_valid;
  assign out_free = !out_valid || out_ready;

  assign lane_k    = 2'(3'd4 - prefix_left);
  assign lane_t    = 2'(header_pos - 3'd2);
  assign bytes_dec = bytes_left - 32'd1;
  assign type_full = {in_byte, type_reg[7:0]};

  always_comb begin
    if (prefix_lead[7:4] == 4'd0) begin
      acc_prefix = size_accum | ({24'd0, in_byte} << {lane_k, 3'b000});
    end else begin
      acc_prefix = {size_accum[23:0], in_byte};
    end
    acc_time = size_accum | ({24'd0, in_byte} << {lane_t, 3'b000});
  end

  always_comb begin
    phase_next       = phase;
    prefix_lead_next = prefix_lead;
    prefix_left_next = prefix_left;
    size_accum_next  = size_accum;
    bytes_left_next  = bytes_left;
    header_pos_next  = header_pos;
    type_reg_next    = type_reg;
    time_reg_next    = time_reg;
    res_valid        = 1'b0;
    res              = '0;
    start            = 1'b0;
    start_size       = 32'd0;

    case (phase)
      PH_FIRST: begin
        if (in_byte[7]) begin
          start      = 1'b1;
          start_size = {25'd0, in_byte[6:0]};
        end else begin
          prefix_lead_next = in_byte;
          size_accum_next  = 32'd0;
          if (in_byte[6]) begin
            prefix_left_next = 3'd1;
          end else if (in_byte[5]) begin
            prefix_left_next = 3'd2;
          end else if (in_byte[4]) begin
            prefix_left_next = 3'd3;
          end else begin
            prefix_left_next = 3'd4;
          end
          phase_next = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        size_accum_next  = acc_prefix;
        prefix_left_next = prefix_left - 3'd1;
        if (prefix_left == 3'd1) begin
          start = 1'b1;
          if (prefix_lead[6]) begin
            start_size = {16'd0, prefix_lead, acc_prefix[7:0]} ^ MARK_2B;
          end else if (prefix_lead[5]) begin
            start_size = {8'd0, prefix_lead, acc_prefix[15:0]} ^ MARK_3B;
          end else if (prefix_lead[4]) begin
            start_size = {prefix_lead, acc_prefix[23:0]} ^ MARK_4B;
          end else begin
            start_size = acc_prefix;
          end
        end
      end
      PH_TYPE: begin
        bytes_left_next = bytes_dec;
        if (header_pos == 3'd0) begin
          type_reg_next   = {8'd0, in_byte};
          header_pos_next = 3'd1;
          if (bytes_dec == 32'd0) begin
            res_valid       = 1'b1;
            res.kind        = KIND_HEADER;
            res.timestamp   = time_reg;
            res.last        = 1'b1;
            phase_next      = PH_FIRST;
          end
        end else if (type_full[4] || bytes_dec == 32'd0) begin
          type_reg_next   = type_full & ~TYPE_REUSE_BIT;
          res_valid       = 1'b1;
          res.kind        = KIND_HEADER;
          res.packet_type = type_full & ~TYPE_REUSE_BIT;
          res.timestamp   = time_reg;
          res.body_length = bytes_dec;
          res.last        = (bytes_dec == 32'd0);
          phase_next      = (bytes_dec == 32'd0) ? PH_FIRST : PH_BODY;
        end else begin
          type_reg_next   = type_full;
          header_pos_next = 3'd2;
          size_accum_next = 32'd0;
          phase_next      = PH_TIME;
        end
      end
      PH_TIME: begin
        bytes_left_next = bytes_dec;
        size_accum_next = acc_time;
        header_pos_next = header_pos + 3'd1;
        if (header_pos == 3'd5 || bytes_dec == 32'd0) begin
          if (header_pos == 3'd5) begin
            time_reg_next = acc_time;
          end
          res_valid       = 1'b1;
          res.kind        = KIND_HEADER;
          res.packet_type = type_reg;
          res.timestamp   = (header_pos == 3'd5) ? acc_time : time_reg;
          res.body_length = bytes_dec;
          res.last        = (bytes_dec == 32'd0);
          phase_next      = (bytes_dec == 32'd0) ? PH_FIRST : PH_BODY;
        end
      end
      PH_BODY: begin
        bytes_left_next = bytes_dec;
        res_valid       = 1'b1;
        res.kind        = KIND_BODY;
        res.body_byte   = in_byte;
        res.last        = (bytes_dec == 32'd0);
        if (bytes_dec == 32'd0) begin
          phase_next = PH_FIRST;
        end
      end
      PH_STOP: begin
        phase_next = PH_STOP;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase

    if (start) begin
      if (start_size == 32'd0) begin
        phase_next = PH_STOP;
        res_valid  = 1'b1;
        res.kind   = KIND_END;
      end else begin
        bytes_left_next = start_size;
        header_pos_next = 3'd0;
        type_reg_next   = 16'd0;
        size_accum_next = 32'd0;
        phase_next      = PH_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      prefix_lead <= 8'd0;
      prefix_left <= 3'd0;
      size_accum  <= 32'd0;
      bytes_left  <= 32'd0;
      header_pos  <= 3'd0;
      type_reg    <= 16'd0;
      time_reg    <= 32'd0;
    end else if (accept) begin
      phase       <= phase_next;
      prefix_lead <= prefix_lead_next;
      prefix_left <= prefix_left_next;
      size_accum  <= size_accum_next;
      bytes_left  <= bytes_left_next;
      header_pos  <= header_pos_next;
      type_reg    <= type_reg_next;
      time_reg    <= time_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_fire) begin
        out_res <= res;
      end
    end else if (res_fire) begin
      skid_res <= res;
    end
  end

  assign kind        = out_res.kind;
  assign body_byte   = out_res.body_byte;
  assign packet_type = out_res.packet_type;
  assign timestamp   = out_res.timestamp;
  assign body_length = out_res.body_length;
  assign last        = out_res.last;

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || out_valid)
  `ASSERT_NEXT(a_stop_holds, clk, rst, phase == PH_STOP, phase == PH_STOP)
  `ASSERT_ALWAYS(a_body_clean, clk, rst,
    !(out_valid && kind == KIND_BODY) || (packet_type == 16'd0 && body_length == 32'd0))
  `ASSERT_ALWAYS(a_end_not_last, clk, rst, !(out_valid && kind == KIND_END) || !last)

endmodule

### test/tb_length_prefixed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer_core
// Self-checking bench for the packet deframer. A short table of hand-picked
// packets (one type byte only, full timestamp, reused timestamp with empty
// body, cut inside the timestamp) opens the run, followed by random packets
// over all five size forms with random header and body bytes. The run closes
// on a zero-size prefix and a few bytes that must be dropped. Every byte goes
// through a bit-accurate deframer model and each result is compared field by
// field. Both sides stall at random, and one long output hold backs up the
// input.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lppd_pkg::*;

  localparam int RANDOM_ITEMS    = 1650;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_START      = 400;
  localparam int HOLD_CYCLES     = 48;
  localparam int CALM_START      = 1200;
  localparam int CALM_END        = 1800;
  localparam int REPORT_LIMIT    = 10;

  typedef enum int {FORM_1B, FORM_2B, FORM_3B, FORM_4B, FORM_5B} prefix_form_t;

  typedef struct packed {
    logic [7:0] val;
    logic       typed;
    result_t    fixed;
  } stim_row_t;

  localparam result_t END_RESULT = '{KIND_END, 8'h00, 16'h0000, 32'h0, 32'h0, 1'b0};

  localparam stim_row_t OPENING_ROWS [26] = '{
    // one-byte size 1, packet ends after the first type byte
    '{8'h81, 1'b0, '0},
    '{8'h5a, 1'b1, '{KIND_HEADER, 8'h00, 16'h0000, 32'h0000_0000, 32'd0, 1'b1}},
    // two-byte size 8, full timestamp, two body bytes
    '{8'h40, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hff, 1'b0, '0},
    '{8'hff, 1'b0, '0},
    '{8'hff, 1'b0, '0},
    '{8'hff, 1'b1, '{KIND_HEADER, 8'h00, 16'h8001, 32'hffff_ffff, 32'd2, 1'b0}},
    '{8'h00, 1'b1, '{KIND_BODY, 8'h00, 16'h0000, 32'h0, 32'd0, 1'b0}},
    '{8'hff, 1'b1, '{KIND_BODY, 8'hff, 16'h0000, 32'h0, 32'd0, 1'b1}},
    // three-byte size 2, timestamp reused, empty body
    '{8'h20, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hff, 1'b0, '0},
    '{8'hff, 1'b1, '{KIND_HEADER, 8'h00, 16'hffef, 32'hffff_ffff, 32'd0, 1'b1}},
    // five-byte size 4, packet ends inside the timestamp
    '{8'h00, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h11, 1'b0, '0},
    '{8'h22, 1'b1, '{KIND_HEADER, 8'h00, 16'h0000, 32'hffff_ffff, 32'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  body_byte;
  logic [15:0] packet_type;
  logic [31:0] timestamp;
  logic [31:0] body_length;
  logic        last;

  stim_row_t   byte_feed [$];
  stim_row_t   fed_row;
  result_t     pending_results [$];
  logic        all_fed = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_count = 0;
  logic        hold_used = 1'b0;
  wire         calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

  // deframer model state
  phase_t      dp_phase = PH_FIRST;
  logic [7:0]  lead_byte = '0;
  logic [2:0]  prefix_count = '0;
  logic [31:0] accum = '0;
  logic [31:0] remain = '0;
  logic [2:0]  hdr_pos = '0;
  logic [15:0] type_acc = '0;
  logic [31:0] held_time = '0;

  length_prefixed_packet_deframer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .body_byte   (body_byte),
    .packet_type (packet_type),
    .timestamp   (timestamp),
    .body_length (body_length),
    .last        (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit start_packet(input logic [31:0] sz, output result_t r);
    r = '0;
    if (sz == 0) begin
      dp_phase = PH_STOP;
      r = END_RESULT;
      return 1'b1;
    end
    remain = sz;
    hdr_pos = 3'd0;
    type_acc = 16'h0000;
    accum = 32'h0;
    dp_phase = PH_TYPE;
    return 1'b0;
  endfunction

  function automatic bit header_out(input logic [15:0] ty, output result_t r);
    r = '0;
    r.kind = KIND_HEADER;
    r.packet_type = ty;
    r.timestamp = held_time;
    r.body_length = remain;
    r.last = (remain == 0);
    dp_phase = (remain == 0) ? PH_FIRST : PH_BODY;
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [31:0] sz;
    r = '0;
    case (dp_phase)
      PH_FIRST: begin
        if (b[7]) return start_packet({25'd0, b[6:0]}, r);
        lead_byte = b;
        accum = 32'h0;
        prefix_count = b[6] ? 3'd1 : b[5] ? 3'd2 : b[4] ? 3'd3 : 3'd4;
        dp_phase = PH_PREFIX;
        return 1'b0;
      end
      PH_PREFIX: begin
        if (lead_byte[7:4] == 4'h0) begin
          accum = accum | (32'(b) << (8 * ((4 - prefix_count) % 4)));
        end else begin
          accum = {accum[23:0], b};
        end
        prefix_count = prefix_count - 3'd1;
        if (prefix_count != 0) return 1'b0;
        if (lead_byte[6]) sz = {16'd0, lead_byte, accum[7:0]} ^ MARK_2B;
        else if (lead_byte[5]) sz = {8'd0, lead_byte, accum[15:0]} ^ MARK_3B;
        else if (lead_byte[4]) sz = {lead_byte, accum[23:0]} ^ MARK_4B;
        else sz = accum;
        return start_packet(sz, r);
      end
      PH_TYPE: begin
        remain = remain - 1;
        if (hdr_pos == 0) begin
          type_acc = {8'h00, b};
          hdr_pos = 3'd1;
          if (remain == 0) return header_out(16'h0000, r);
          return 1'b0;
        end
        type_acc = {b, type_acc[7:0]};
        if ((type_acc & TYPE_REUSE_BIT) != 0) begin
          type_acc = type_acc ^ TYPE_REUSE_BIT;
          return header_out(type_acc, r);
        end
        if (remain == 0) return header_out(type_acc, r);
        hdr_pos = 3'd2;
        accum = 32'h0;
        dp_phase = PH_TIME;
        return 1'b0;
      end
      PH_TIME: begin
        remain = remain - 1;
        accum = accum | (32'(b) << (8 * (hdr_pos - 2)));
        hdr_pos = hdr_pos + 3'd1;
        if (hdr_pos >= 6) begin
          held_time = accum;
          return header_out(type_acc, r);
        end
        if (remain == 0) return header_out(type_acc, r);
        return 1'b0;
      end
      PH_BODY: begin
        remain = remain - 1;
        r.kind = KIND_BODY;
        r.body_byte = b;
        r.last = (remain == 0);
        if (remain == 0) dp_phase = PH_FIRST;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin : feed
    result_t predicted;
    bit      has_result;
    if (rst) begin
      in_valid <= 1'b0;
      dp_phase = PH_FIRST;
      held_time = 32'h0;
    end else begin
      if (in_valid && in_ready) begin
        has_result = deframe_byte(in_byte, predicted);
        if (has_result || fed_row.typed) begin
          pending_results.push_back(fed_row.typed ? fed_row.fixed : predicted);
        end
      end
      if (!in_valid || in_ready) begin
        if (byte_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          fed_row = byte_feed.pop_front();
          in_valid <= 1'b1;
          in_byte <= fed_row.val;
        end else begin
          in_valid <= 1'b0;
          if (byte_feed.size() == 0) all_fed <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : drain
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result %0d: kind %0d byte %02h type %04h",
                                 results_seen, kind, body_byte, packet_type));
        end else begin
          want = pending_results.pop_front();
          if (kind !== want.kind || body_byte !== want.body_byte ||
              packet_type !== want.packet_type || timestamp !== want.timestamp ||
              body_length !== want.body_length || last !== want.last) begin
            log_mismatch($sformatf({"mismatch on result %0d: expected kind %0d byte %02h ",
                                    "type %04h time %08h length %0d last %0d, got kind %0d ",
                                    "byte %02h type %04h time %08h length %0d last %0d"},
                                   results_seen, want.kind, want.body_byte,
                                   want.packet_type, want.timestamp, want.body_length,
                                   want.last, kind, body_byte, packet_type, timestamp,
                                   body_length, last));
          end
        end
      end
      if (hold_count != 0) begin
        hold_count <= hold_count - 1;
        out_ready <= 1'b0;
      end else if (!hold_used && cycle_count >= HOLD_START) begin
        hold_used <= 1'b1;
        hold_count <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin
    int unsigned  size;
    int unsigned  random_bytes;
    prefix_form_t form;
    logic [31:0]  sz32;
    logic [7:0]   prefix [$];
    stim_row_t    row;
    bit           timed_out;

    timed_out = 1'b0;
    foreach (OPENING_ROWS[i]) byte_feed.push_back(OPENING_ROWS[i]);

    // random packets, closed by a zero-size prefix in a random form
    random_bytes = 0;
    do begin
      if (random_bytes >= RANDOM_ITEMS) size = 0;
      else if ($urandom_range(0, 9) == 0) size = $urandom_range(1, 6);
      else if ($urandom_range(0, 19) == 0) size = $urandom_range(128, 300);
      else size = $urandom_range(7, 40);
      form = prefix_form_t'($urandom_range(0, 4));
      if (form == FORM_1B && size > 127) form = FORM_2B;
      sz32 = size;
      prefix.delete();
      case (form)
        FORM_1B: prefix.push_back(8'h80 | sz32[7:0]);
        FORM_2B: begin
          prefix.push_back(8'h40 | sz32[15:8]);
          prefix.push_back(sz32[7:0]);
        end
        FORM_3B: begin
          prefix.push_back(8'h20 | sz32[23:16]);
          prefix.push_back(sz32[15:8]);
          prefix.push_back(sz32[7:0]);
        end
        FORM_4B: begin
          prefix.push_back(8'h10 | sz32[31:24]);
          prefix.push_back(sz32[23:16]);
          prefix.push_back(sz32[15:8]);
          prefix.push_back(sz32[7:0]);
        end
        default: begin
          prefix.push_back(8'($urandom_range(0, 15)));
          prefix.push_back(sz32[7:0]);
          prefix.push_back(sz32[15:8]);
          prefix.push_back(sz32[23:16]);
          prefix.push_back(sz32[31:24]);
        end
      endcase
      foreach (prefix[i]) begin
        row.val = prefix[i];
        row.typed = (size == 0) && (i == prefix.size() - 1);
        row.fixed = row.typed ? END_RESULT : '0;
        byte_feed.push_back(row);
      end
      row.typed = 1'b0;
      row.fixed = '0;
      repeat (size) begin
        row.val = 8'($urandom);
        byte_feed.push_back(row);
      end
      random_bytes += prefix.size() + size;
    end while (size != 0);

    // drop everything after the end of stream
    repeat (8) begin
      row.val = 8'($urandom);
      byte_feed.push_back(row);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(all_fed && pending_results.size() == 0) && !timed_out) begin
      @(negedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);

    if (timed_out) begin
      $display("== FAIL ==");
    end else if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
